// ===== src/mvp_pkg.sv =====
package mvp_pkg;

	localparam int LANES        = 16;
	localparam int VDEPTH_DEF   = 1024;
	localparam int VLEN_W       = 11;
	localparam int ROWS_W       = 16;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;
	localparam int FP_W         = 32;

	localparam logic [VLEN_W-1:0] VLEN_RST = 11'd1024;
	localparam logic [ROWS_W-1:0] ROWS_RST = 16'd1;
	localparam logic [FP_W-1:0]   QNAN     = 32'h7FC0_0000;
	localparam logic [FP_W-1:0]   POS_ZERO = 32'h0000_0000;

	// register index as decoded from paddr[2]
	typedef enum logic {
		REG_VLEN = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_MATRIX  = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// leading zero count over 48 bits
	function automatic logic [5:0] lzc48(input logic [47:0] x);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (x[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// round to nearest even and pack; sig[26] is the leading one, sig[2] round, sig[1:0] sticky
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
			input logic [26:0] sig);
		logic [26:0]        sig2;
		logic [7:0]         ef;
		logic signed [11:0] shv;
		logic [4:0]         sh;
		logic [23:0]        m;
		logic               inc;
		logic [30:0]        body;
		sig2 = sig;
		ef   = 8'd0;
		shv  = 12'sd0;
		sh   = 5'd0;
		if (sig == 27'd0) return {s, 31'd0};
		if (e > 12'sd254) return {s, 8'hFF, 23'd0};
		if (e < 12'sd1) begin
			shv = 12'sd1 - e;
			if (shv > 12'sd26) begin
				sig2 = {26'd0, |sig};
			end else begin
				sh   = shv[4:0];
				sig2 = (sig >> sh) | {26'd0, |(sig & ~({27{1'b1}} << sh))};
			end
		end else begin
			ef = e[7:0];
		end
		m    = sig2[26:3];
		inc  = sig2[2] & ((|sig2[1:0]) | m[0]);
		body = {ef, m[22:0]} + {30'd0, inc};
		return {s, body};
	endfunction

	function automatic logic fp_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// binary32 multiply, subnormals kept
	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic               s;
		logic               a_inf, b_inf, a_zero, b_zero;
		logic [23:0]        ma, mb;
		logic [7:0]         ea, eb;
		logic [47:0]        p, pn;
		logic [5:0]         lz;
		logic signed [11:0] e;
		s      = a[31] ^ b[31];
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
		if ((a_inf && b_zero) || (b_inf && a_zero)) return QNAN;
		if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
		if (a_zero || b_zero) return {s, 31'd0};
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p  = ma * mb;
		lz = lzc48(p);
		pn = p << lz;
		e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
		return round_pack(s, e, {pn[47:22], |pn[21:0]});
	endfunction

	// binary32 add, subnormals kept
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic               a_inf, b_inf;
		logic [31:0]        x, y;
		logic [23:0]        mx, my;
		logic [7:0]         ex, ey, d;
		logic [27:0]        xv, yf, yv, sum;
		logic [5:0]         lz, sh;
		logic [26:0]        sig;
		logic signed [11:0] e;
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
		if (a_inf && b_inf && (a[31] != b[31])) return QNAN;
		if (a_inf) return a;
		if (b_inf) return b;
		if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
		if (a[30:0] >= b[30:0]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		mx = {x[30:23] != 8'd0, x[22:0]};
		my = {y[30:23] != 8'd0, y[22:0]};
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d  = ex - ey;
		xv = {1'b0, mx, 3'd0};
		yf = {1'b0, my, 3'd0};
		if (d > 8'd26) yv = {27'd0, 1'b1};
		else yv = (yf >> d[4:0]) | {27'd0, |(yf & ~({28{1'b1}} << d[4:0]))};
		sum = (x[31] == y[31]) ? (xv + yv) : (xv - yv);
		if (sum == 28'd0) return POS_ZERO;
		lz = lzc48({sum, 20'd0});
		if (sum[27]) begin
			sig = sum[27:1] | {26'd0, sum[0]};
			e   = $signed({4'd0, ex}) + 12'sd1;
		end else begin
			sh  = lz - 6'd1;
			sig = sum[26:0] << sh;
			e   = $signed({4'd0, ex}) - $signed({6'd0, sh});
		end
		return round_pack(x[31], e, sig);
	endfunction

endpackage

// ===== src/mvp_ram.sv =====
module mvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/mvp_lane.sv =====
module mvp_lane (
	input  logic        clk,
	input  logic [31:0] vec_elem,
	input  logic [31:0] weight,
	output logic [31:0] prod_s1
);
	import mvp_pkg::*;

	// one lane product, registered
	always_ff @(posedge clk) begin
		prod_s1 <= fp_mul(vec_elem, weight);
	end
endmodule

// ===== src/mvp_tree.sv =====
module mvp_tree (
	input  logic                                     clk,
	input  logic [mvp_pkg::LANES*mvp_pkg::FP_W-1:0] prod,
	output logic [mvp_pkg::FP_W-1:0]                 total_s5
);
	import mvp_pkg::*;

	logic [FP_W-1:0] lvl1_s2 [8];
	logic [FP_W-1:0] lvl2_s3 [4];
	logic [FP_W-1:0] lvl3_s4 [2];

	// pairwise merge of lane products, one level per stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			lvl1_s2[i] <= fp_add(prod[64*i +: 32], prod[64*i+32 +: 32]);
		end
		for (int i = 0; i < 4; i++) begin
			lvl2_s3[i] <= fp_add(lvl1_s2[2*i], lvl1_s2[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			lvl3_s4[i] <= fp_add(lvl2_s3[2*i], lvl2_s3[2*i+1]);
		end
		total_s5 <= fp_add(lvl3_s4[0], lvl3_s4[1]);
	end
endmodule

// ===== src/fp32_matrix_vector_product_unit.sv =====
// a matrix tile goes from transfer to result register through these stages
// (vector store read, lane multiply, four merge levels, row accumulate)
// in_stall is high while a tile is in the single shared pipeline and while a finished
// row waits on out_stall; vector loads, restarts and no-ops leave the sequencer idle
// reset: pointers, row counter and running sum clear, registers take defaults;
// the vector store is not cleared
module fp32_matrix_vector_product_unit #(
	parameter int VECTOR_DEPTH = mvp_pkg::VDEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [63:0]                   lane_pair_0,
	input  logic [63:0]                   lane_pair_1,
	input  logic [63:0]                   lane_pair_2,
	input  logic [63:0]                   lane_pair_3,
	input  logic [63:0]                   lane_pair_4,
	input  logic [63:0]                   lane_pair_5,
	input  logic [63:0]                   lane_pair_6,
	input  logic [63:0]                   lane_pair_7,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   row_result,
	output logic [15:0]                   row_index,
	output logic                          last_row,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mvp_pkg::ADDR_W-1:0]    paddr,
	input  logic [mvp_pkg::DATA_W-1:0]    pwdata,
	output logic [mvp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import mvp_pkg::*;

	localparam int MAX_TILES = VECTOR_DEPTH / LANES;
	localparam int TILE_W    = $clog2(MAX_TILES + 1);
	localparam int RAM_AW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int CNT_W     = (TILE_W > 7) ? TILE_W : 7;
	localparam int WORD_W    = LANES * FP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_ACC
	} state_t;

	state_t              state_q;
	logic [2:0]          cnt_q;
	logic [VLEN_W-1:0]   vlen_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [TILE_W-1:0]   ltp_q;
	logic [TILE_W-1:0]   rtp_q;
	logic [15:0]         row_q;
	logic [FP_W-1:0]     sum_q;
	logic [WORD_W-1:0]   weight_q;
	logic [WORD_W-1:0]   in_word;
	logic [WORD_W-1:0]   vec_word;
	logic [WORD_W-1:0]   prod_word;
	logic [FP_W-1:0]     total_s5;
	logic [FP_W-1:0]     next_sum;
	logic                in_xfer;
	logic                cfg_wr;
	logic                ram_we;
	logic [RAM_AW-1:0]   rd_tile;
	logic [CNT_W-1:0]    tiles;
	logic [CNT_W-1:0]    rtp_next;
	logic                row_done;
	logic                out_busy;
	logic                res_load;

	assign in_word = {lane_pair_7, lane_pair_6, lane_pair_5, lane_pair_4,
		lane_pair_3, lane_pair_2, lane_pair_1, lane_pair_0};
	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register readback
	assign prdata = (reg_idx_t'(paddr[2]) == REG_ROWS) ? DATA_W'(rows_q) : DATA_W'(vlen_q);

	// tiles per row: capped at store depth, at least one
	always_comb begin
		tiles = CNT_W'(vlen_q[VLEN_W-1:4]);
		if (tiles > CNT_W'(MAX_TILES)) tiles = CNT_W'(MAX_TILES);
		if (tiles == '0) tiles = CNT_W'(1);
	end

	// tile read address, clamped to the last tile
	assign rd_tile = (rtp_q >= TILE_W'(MAX_TILES)) ? RAM_AW'(MAX_TILES - 1) : RAM_AW'(rtp_q);
	assign ram_we  = in_xfer && (op_t'(operation) == OP_LOAD) && (ltp_q < TILE_W'(MAX_TILES));

	mvp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_TILES)
	) u_vec_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(RAM_AW'(ltp_q)),
		.wdata(in_word),
		.raddr(rd_tile),
		.rdata(vec_word)
	);

	// weights held for the tile in flight
	always_ff @(posedge clk) begin
		if (in_xfer) weight_q <= in_word;
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mvp_lane u_lane (
			.clk     (clk),
			.vec_elem(vec_word[FP_W*g +: FP_W]),
			.weight  (weight_q[FP_W*g +: FP_W]),
			.prod_s1 (prod_word[FP_W*g +: FP_W])
		);
	end

	mvp_tree u_tree (
		.clk     (clk),
		.prod    (prod_word),
		.total_s5(total_s5)
	);

	assign next_sum = fp_add(sum_q, total_s5);
	assign rtp_next = CNT_W'(rtp_q) + CNT_W'(1);
	assign row_done = (rtp_next >= tiles);
	assign out_busy = out_valid && out_stall;
	assign res_load = (state_q == S_ACC) && row_done && !out_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VLEN_RST;
			rows_q <= ROWS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_VLEN: vlen_q <= pwdata[VLEN_W-1:0];
				REG_ROWS: rows_q <= pwdata[ROWS_W-1:0];
				default:  ;
			endcase
		end
	end

	// sequencer, pointers, running sum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			ltp_q      <= '0;
			rtp_q      <= '0;
			row_q      <= '0;
			sum_q      <= POS_ZERO;
			out_valid  <= 1'b0;
			row_result <= '0;
			row_index  <= '0;
			last_row   <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !res_load) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (op_t'(operation))
							OP_LOAD: begin
								if (ram_we) ltp_q <= ltp_q + TILE_W'(1);
							end
							OP_MATRIX: begin
								state_q <= S_RUN;
								cnt_q   <= '0;
							end
							OP_RESTART: begin
								ltp_q <= '0;
								rtp_q <= '0;
								row_q <= '0;
								sum_q <= POS_ZERO;
							end
							OP_NONE: ;
							default: ;
						endcase
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) state_q <= S_ACC;
				end
				S_ACC: begin
					if (!row_done) begin
						sum_q   <= next_sum;
						rtp_q   <= TILE_W'(rtp_next);
						state_q <= S_IDLE;
					end else if (!out_busy) begin
						out_valid  <= 1'b1;
						row_result <= fp_is_nan(next_sum) ? QNAN : next_sum;
						row_index  <= row_q;
						last_row   <= (row_q == rows_q - 16'd1);
						row_q      <= (row_q == rows_q - 16'd1) ? 16'd0 : row_q + 16'd1;
						rtp_q      <= '0;
						sum_q      <= POS_ZERO;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_matrix_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (op_t'(operation) == OP_MATRIX) |=> state_q == S_RUN)
		else $error("matrix tile transfer did not start the pipeline");
	a_result_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_ACC)
		else $error("result raised outside accumulate step");
	a_rtp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rtp_q < TILE_W'(MAX_TILES))
		else $error("row tile pointer out of range");
	a_ltp_range: assert property (@(posedge clk) disable iff (!arst_n)
		ltp_q <= TILE_W'(MAX_TILES))
		else $error("load tile pointer out of range");
`endif
endmodule
